[rtl/core/circular_fifo_queue_assert.svh]
// Assertion macros for the circular FIFO queue checker.
// Used by the checker module; depends on nothing else.
`ifndef CIRCULAR_FIFO_QUEUE_ASSERT_SVH
`define CIRCULAR_FIFO_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define CFQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define CFQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/cfq_pkg.sv]
// Shared types and codes for the circular FIFO queue.
// Used by every module of the block; depends on nothing.
package cfq_pkg;

   localparam logic [1:0] CMD_ENQ  = 2'd0;
   localparam logic [1:0] CMD_DEQ  = 2'd1;
   localparam logic [1:0] CMD_SHOW = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   localparam int OPQ_DEPTH = 2;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] data;
      logic               data_valid;
      logic               last;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_ENQ,
      OP_DEQ,
      OP_SHOW
   } op_kind_type;

   typedef struct packed {
      op_kind_type        kind;
      logic signed [31:0] value;
   } op_type;

   typedef enum logic {
      BK_IDLE,
      BK_SHOW
   } back_state_type;

endpackage

[rtl/core/circular_fifo_queue.sv]
// Top level of the circular FIFO queue of signed 32-bit words.
// Instantiates cfq_front, cfq_opq and cfq_back; depends on cfq_pkg.
//
// A request beat is taken when start is high and busy is low. Each result
// beat shows on rsp_item for one cycle with rsp_strobe high, once its
// request has passed the operation queue and the back end's result
// register, and the receiver cannot stall it. Requests pass through a
// two-entry operation queue, so busy rises only when that queue is full.
// Enqueue and dequeue are handled by the back end, which holds the
// storage with one write and one registered read port, so they sustain one
// request per cycle while no display holds the back end. A display walks
// the stored words from head to tail, a beat per word, holding the back
// end; an empty queue gives one ST_EMPTY beat. Command code 3 is dropped.
module circular_fifo_queue import cfq_pkg::*; #(
   parameter int DEPTH = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   logic   op_push;
   op_type op_new;
   logic   op_valid;
   op_type op_head;
   logic   op_pop;

   cfq_front u_front (
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .op_push  (op_push),
      .op_out   (op_new)
   );

   cfq_opq u_opq (
      .clock    (clock),
      .reset    (reset),
      .op_push  (op_push),
      .op_in    (op_new),
      .op_pop   (op_pop),
      .op_valid (op_valid),
      .op_head  (op_head),
      .full     (busy)
   );

   cfq_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .op_valid   (op_valid),
      .op_head    (op_head),
      .op_pop     (op_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

[rtl/core/cfq_front.sv]
// Front end of the circular FIFO queue: takes request beats and turns them
// into operations for the back end. Depends on cfq_pkg.
module cfq_front import cfq_pkg::*; (
   input  logic    start,
   input  logic    busy,
   input  req_type req_item,
   output logic    op_push,
   output op_type  op_out
);

   always_comb begin
      op_push      = 1'b0;
      op_out.kind  = OP_ENQ;
      op_out.value = req_item.value;
      case (req_item.cmd)
         CMD_ENQ: begin
            op_push     = start && !busy;
            op_out.kind = OP_ENQ;
         end
         CMD_DEQ: begin
            op_push     = start && !busy;
            op_out.kind = OP_DEQ;
         end
         CMD_SHOW: begin
            op_push     = start && !busy;
            op_out.kind = OP_SHOW;
         end
         default: begin
            op_push = 1'b0;
         end
      endcase
   end

endmodule

[rtl/core/cfq_opq.sv]
// Short operation queue between the front and back ends of the circular
// FIFO queue. Depends on cfq_pkg.
module cfq_opq import cfq_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   op_push,
   input  op_type op_in,
   input  logic   op_pop,
   output logic   op_valid,
   output op_type op_head,
   output logic   full
);

   localparam int PW = $clog2(OPQ_DEPTH);
   localparam int FW = $clog2(OPQ_DEPTH + 1);

   op_type          slot_ff [OPQ_DEPTH];
   logic [PW-1:0]   wptr_ff;
   logic [PW-1:0]   wptr_in;
   logic [PW-1:0]   rptr_ff;
   logic [PW-1:0]   rptr_in;
   logic [FW-1:0]   fill_ff;
   logic [FW-1:0]   fill_in;
   logic            do_push;
   logic            do_pop;

   assign full     = (fill_ff == FW'(OPQ_DEPTH));
   assign op_valid = (fill_ff != '0);
   assign op_head  = slot_ff[rptr_ff];
   assign do_push  = op_push && !full;
   assign do_pop   = op_pop && op_valid;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PW'(OPQ_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PW'(OPQ_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= op_in;
      end
   end

endmodule

[rtl/core/cfq_back.sv]
// Back end of the circular FIFO queue: word storage, head, tail and count,
// the display walk and the result register. Depends on cfq_pkg.
module cfq_back import cfq_pkg::*; #(
   parameter int DEPTH = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    op_valid,
   input  op_type  op_head,
   output logic    op_pop,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);

   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] rd_data_ff;
   logic [IW-1:0]      rd_addr;
   logic               wr_en;

   back_state_type state_ff;
   back_state_type state_in;
   logic [IW-1:0]  head_ff;
   logic [IW-1:0]  head_in;
   logic [IW-1:0]  tail_ff;
   logic [IW-1:0]  tail_in;
   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  count_in;
   logic [IW-1:0]  walk_ff;
   logic [IW-1:0]  walk_in;
   logic [CW-1:0]  left_ff;
   logic [CW-1:0]  left_in;

   logic           res_valid_ff;
   logic           res_valid_in;
   logic [1:0]     res_status_ff;
   logic [1:0]     res_status_in;
   logic           res_dv_ff;
   logic           res_dv_in;
   logic           res_last_ff;
   logic           res_last_in;

   logic           is_full;
   logic           is_empty;

   assign is_full  = (count_ff == CW'(DEPTH));
   assign is_empty = (count_ff == '0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (op_valid && (op_head.kind == OP_SHOW) && !is_empty) begin
               state_in = BK_SHOW;
            end
         end
         BK_SHOW: begin
            if (left_ff == CW'(1)) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      op_pop        = 1'b0;
      wr_en         = 1'b0;
      rd_addr       = head_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      walk_in       = walk_ff;
      left_in       = left_ff;
      res_valid_in  = 1'b0;
      res_status_in = ST_OK;
      res_dv_in     = 1'b0;
      res_last_in   = 1'b1;
      case (state_ff)
         BK_IDLE: begin
            if (op_valid) begin
               op_pop       = 1'b1;
               res_valid_in = 1'b1;
               case (op_head.kind)
                  OP_ENQ: begin
                     if (is_full) begin
                        res_status_in = ST_OVERFLOW;
                     end else begin
                        wr_en    = 1'b1;
                        tail_in  = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_DEQ: begin
                     if (is_empty) begin
                        res_status_in = ST_UNDERFLOW;
                     end else begin
                        res_dv_in = 1'b1;
                        head_in   = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
                        count_in  = count_ff - 1'b1;
                     end
                  end
                  OP_SHOW: begin
                     if (is_empty) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        res_valid_in = 1'b0;
                        walk_in      = head_ff;
                        left_in      = count_ff;
                     end
                  end
                  default: begin
                     res_valid_in = 1'b0;
                  end
               endcase
            end
         end
         BK_SHOW: begin
            rd_addr      = walk_ff;
            res_valid_in = 1'b1;
            res_dv_in    = 1'b1;
            res_last_in  = (left_ff == CW'(1));
            walk_in      = (walk_ff == LAST_SLOT) ? '0 : walk_ff + 1'b1;
            left_in      = left_ff - 1'b1;
         end
         default: begin
            res_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff       <= walk_in;
      left_ff       <= left_in;
      res_status_ff <= res_status_in;
      res_dv_ff     <= res_dv_in;
      res_last_ff   <= res_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= op_head.value;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_strobe          = res_valid_ff;
   assign rsp_item.status     = res_status_ff;
   assign rsp_item.data       = res_dv_ff ? rd_data_ff : '0;
   assign rsp_item.data_valid = res_dv_ff;
   assign rsp_item.last       = res_last_ff;

endmodule

[rtl/core/cfq_checker.sv]
// Port-level checks for the circular FIFO queue, bound to the top level.
// Depends on cfq_pkg and circular_fifo_queue_assert.svh.
`include "circular_fifo_queue_assert.svh"

module cfq_checker import cfq_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   logic mid_beat;
   logic word_beat;
   logic err_beat;
   logic bare_beat;

   assign mid_beat  = rsp_strobe && !rsp_item.last;
   assign word_beat = rsp_strobe && rsp_item.data_valid && (rsp_item.status == ST_OK);
   assign err_beat  = rsp_strobe && (rsp_item.status != ST_OK);
   assign bare_beat = rsp_strobe && !rsp_item.data_valid;

   `CFQ_ASSERT_NEXT(a_quiet_after_reset, clock, 1'b0, reset, !rsp_strobe, "beat after reset")
   `CFQ_ASSERT_NEXT(a_burst_continues, clock, reset, mid_beat, word_beat, "display burst broken")
   `CFQ_ASSERT_NOW(a_error_single, clock, reset, err_beat, rsp_item.last && !rsp_item.data_valid, "error beat not single")
   `CFQ_ASSERT_NOW(a_data_zero, clock, reset, bare_beat, rsp_item.data == '0, "data not zero")

endmodule

bind circular_fifo_queue cfq_checker u_cfq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

[tb/sv/tb_circular_fifo_queue.sv]
// Self-checking testbench for the circular FIFO queue of signed 32-bit words.
// It predicts enqueue, dequeue and display beats in its own copy of the queue.
// Depends on cfq_pkg and the circular_fifo_queue top level.
`timescale 1ns / 100ps

module tb_circular_fifo_queue;
   import cfq_pkg::*;

   localparam int DEPTH = 8;
   localparam int SW = $clog2(DEPTH);
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [1:0] CMD_NONE = 2'd3;
   localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   logic signed [31:0] fifo_words [DEPTH];
   logic [SW-1:0]      rd_slot = '0;
   logic [SW-1:0]      wr_slot = '0;
   int unsigned        word_count = 0;

   rsp_type due_rsp [$];
   event    rsp_checked;
   int      errors = 0;
   int      cycles = 0;
   bit      no_gaps = 1'b0;

   circular_fifo_queue #(
      .DEPTH(DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_circular_fifo_queue NOT OK");
         $finish;
      end
   end

   function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] slot);
      return (slot == SW'(DEPTH - 1)) ? '0 : slot + 1'b1;
   endfunction

   // Updates the queue copy for one accepted command and queues its beats.
   function automatic void apply_fifo_cmd(input req_type item);
      logic [SW-1:0] slot;
      case (item.cmd)
         CMD_ENQ: begin
            if (word_count >= DEPTH) begin
               due_rsp.push_back('{ST_OVERFLOW, 32'sd0, 1'b0, 1'b1});
            end else begin
               fifo_words[wr_slot] = item.value;
               wr_slot = next_slot(wr_slot);
               word_count++;
               due_rsp.push_back('{ST_OK, 32'sd0, 1'b0, 1'b1});
            end
         end
         CMD_DEQ: begin
            if (word_count == 0) begin
               due_rsp.push_back('{ST_UNDERFLOW, 32'sd0, 1'b0, 1'b1});
            end else begin
               due_rsp.push_back('{ST_OK, fifo_words[rd_slot], 1'b1, 1'b1});
               rd_slot = next_slot(rd_slot);
               word_count--;
            end
         end
         CMD_SHOW: begin
            if (word_count == 0) begin
               due_rsp.push_back('{ST_EMPTY, 32'sd0, 1'b0, 1'b1});
            end else begin
               slot = rd_slot;
               for (int unsigned i = 0; i < word_count; i++) begin
                  due_rsp.push_back('{ST_OK, fifo_words[slot], 1'b1, i + 1 == word_count});
                  slot = next_slot(slot);
               end
            end
         end
         default: begin
         end
      endcase
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("%0t: mismatch on %s, got %h, expected %h", $time, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (due_rsp.size() == 0) begin
            flag_mismatch("unexpected beat", rsp_item.data, 32'd0);
         end else begin
            want = due_rsp.pop_front();
            if (rsp_item.status !== want.status)
               flag_mismatch("status", 32'(rsp_item.status), 32'(want.status));
            if (rsp_item.data !== want.data)
               flag_mismatch("data", rsp_item.data, want.data);
            if (rsp_item.data_valid !== want.data_valid)
               flag_mismatch("data_valid", 32'(rsp_item.data_valid), 32'(want.data_valid));
            if (rsp_item.last !== want.last)
               flag_mismatch("last", 32'(rsp_item.last), 32'(want.last));
         end
         ->rsp_checked;
      end
   end

   task automatic send_cmd(input logic [1:0] cmd, input logic signed [31:0] value);
      req_type item;
      item.cmd = cmd;
      item.value = value;
      if (!no_gaps && $urandom_range(99) < 11) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
      apply_fifo_cmd(item);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (due_rsp.size() != 0) @(rsp_checked);
   endtask

   task automatic test_empty_queue();
      send_cmd(CMD_DEQ, 32'sd0);
      send_cmd(CMD_SHOW, 32'sd0);
      send_cmd(CMD_NONE, -32'sd1);
   endtask

   task automatic test_fill_and_overflow();
      send_cmd(CMD_ENQ, WORD_MIN);
      send_cmd(CMD_ENQ, WORD_MAX);
      send_cmd(CMD_ENQ, 32'sd0);
      send_cmd(CMD_ENQ, -32'sd1);
      send_cmd(CMD_ENQ, 32'sd1);
      send_cmd(CMD_ENQ, 32'sh5555_5555);
      send_cmd(CMD_ENQ, 32'shaaaa_aaaa);
      send_cmd(CMD_ENQ, 32'sh1234_5678);
      send_cmd(CMD_SHOW, 32'sd0);
      send_cmd(CMD_ENQ, 32'sd7);
   endtask

   task automatic test_drain_and_underflow();
      for (int i = 0; i < DEPTH; i++) send_cmd(CMD_DEQ, -32'sd1);
      send_cmd(CMD_DEQ, 32'sd0);
      send_cmd(CMD_SHOW, -32'sd1);
   endtask

   task automatic test_random_traffic();
      int          sent;
      int          enq_pct;
      int unsigned pick;
      logic signed [31:0] value;
      logic [1:0]  cmd;
      sent = 0;
      enq_pct = 50;
      while (sent < 500) begin
         if (sent % 40 == 0) begin
            case ($urandom_range(2))
               0: enq_pct = 80;
               1: enq_pct = 50;
               default: enq_pct = 20;
            endcase
         end
         no_gaps = (sent >= 200 && sent < 300);
         if (sent == 350) wait_drained();
         case ($urandom_range(9))
            0: value = WORD_MIN;
            1: value = WORD_MAX;
            default: value = $urandom;
         endcase
         pick = $urandom_range(99);
         if ($urandom_range(99) < 4) cmd = CMD_NONE;
         else if (pick < enq_pct) cmd = CMD_ENQ;
         else if (pick < enq_pct + (100 - enq_pct) * 3 / 4) cmd = CMD_DEQ;
         else cmd = CMD_SHOW;
         send_cmd(cmd, value);
         if (cmd != CMD_NONE) sent++;
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_queue();
      test_fill_and_overflow();
      test_drain_and_underflow();
      test_random_traffic();
      wait_drained();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("tb_circular_fifo_queue OK");
      end else begin
         $display("tb_circular_fifo_queue NOT OK");
      end
      $finish;
   end

endmodule
